@@ rtl/core/fsti_pkg.sv @@
`timescale 1ns / 1ps
package fsti_pkg;

    localparam int RomDepth = 1024;
    localparam int RomHalf  = 512;
    localparam int MantW    = 23;
    localparam int KeyW     = 10;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;

    typedef logic [2*MantW-1:0] t_rom_word;

    // Round a real to the nearest single-precision value, ties to even, and
    // return it as a real again so that table arithmetic stays in single.
    function automatic real round_single(real d);
        logic [63:0] b;
        logic [34:0] keep;
        logic [28:0] low;
        b    = $realtobits(d);
        keep = b[63:29];
        low  = b[28:0];
        if (low > 29'h1000_0000 || (low == 29'h1000_0000 && keep[0])) begin
            keep = keep + 35'd1;
        end
        return $bitstoreal({keep, 29'b0});
    endfunction

    // Mantissa field of a real that already holds a single-precision value.
    function automatic logic [MantW-1:0] single_mant(real d);
        logic [63:0] b;
        b = $realtobits(d);
        return b[51:29];
    endfunction

endpackage

@@ rtl/core/fsti_if.sv @@
`timescale 1ns / 1ps
interface fsti_operand_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand;
    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

interface fsti_root_if;
    logic        valid;
    logic        ready;
    logic [31:0] root;
    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

@@ rtl/core/fp32_sqrt_table_interp_core.sv @@
`timescale 1ns / 1ps
// Approximate single-precision square root, truncated, by table lookup and
// linear interpolation.
// i_operand carries one request per IEEE word; o_root returns one result
// for each request, in order. Both are valid/ready channels.
// A request passes through three registered stages to o_root. Stage one
// decodes the word and reads the 1024-entry slope/offset table, stage two
// forms the three partial products of the split 13-bit multiply, stage
// three sums, aligns, adds the offset and selects special-case results.
// Throughput is one request per cycle while o_root.ready is high; each
// stage advances whenever the stage after it is empty or advancing, so
// bubbles are squeezed out.
// When the receiver holds o_root.ready low the result stays on o_root and
// the pipeline fills; i_operand.ready drops once all three stages hold
// work, and nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties all stages; the table is
// constant, computed at elaboration, and needs no fill.
// Zeros, denormals, infinities, NaNs and negative inputs bypass the
// arithmetic and are resolved in stage one.
module fp32_sqrt_table_interp_core (
    input logic           i_clk,
    input logic           i_rst_n,
    fsti_operand_if.sink  i_operand,
    fsti_root_if.source   o_root
);
    import fsti_pkg::*;

    logic rdy1, rdy2, rdy3;
    logic r_v1, r_v2, r_v3;

    t_rom_word rom_data [RomDepth];

    // stage 1
    logic [31:0]      in_w;
    logic [7:0]       in_e;
    logic [22:0]      in_m;
    logic [KeyW-1:0]  key;
    logic             n_spec1;
    logic [31:0]      n_sval1;
    logic [7:0]       n_expr1;
    logic [22:0]      r_a1, r_b1, r_m1;
    logic             r_even1, r_spec1;
    logic [31:0]      r_sval1;
    logic [7:0]       r_expr1;

    // stage 2
    logic [12:0] ha, hb;
    logic [25:0] r_hh2;
    logic [12:0] r_lh2, r_hl2;
    logic [22:0] r_b2;
    logic        r_even2, r_spec2;
    logic [31:0] r_sval2;
    logic [7:0]  r_expr2;

    // stage 3
    logic [25:0] mul;
    logic [22:0] mulm;
    logic [24:0] ma, mb;
    logic [25:0] sum;
    logic [22:0] mant;
    logic [31:0] n_root;
    logic [31:0] r_root3;

    // Each entry covers one interval of the input; the upper half of the
    // table covers inputs with an odd unbiased exponent.
    for (genvar k = 0; k < RomDepth; k++) begin : g_rom
        localparam int  N   = ((k & RomHalf) != 0) ? 1024 + 2 * (k & (RomHalf - 1))
                                                   : 512 + k;
        localparam int  DN  = ((k & RomHalf) != 0) ? 2 : 1;
        localparam real S0  = $sqrt(real'(N) / 512.0);
        localparam real S1  = $sqrt(real'(N + DN) / 512.0);
        localparam real AF  = round_single(1.0 / (S0 + S1));
        localparam real TF  = round_single((2.0 * AF) * S0 - 1.0);
        localparam real SQ  = round_single(TF * TF);
        localparam real NUM = round_single(2.0 - SQ);
        localparam real DEN = round_single(8.0 * AF);
        localparam real BF  = round_single(NUM / DEN);
        assign rom_data[k] = {single_mant(AF), single_mant(BF)};
    end

    assign rdy3 = !r_v3 || o_root.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_operand.ready = rdy1;

    assign in_w = i_operand.operand;
    assign in_e = in_w[30:23];
    assign in_m = in_w[22:0];
    assign key  = {~in_e[0], in_m[22:14]};

    always_comb begin
        n_spec1 = 1'b1;
        n_sval1 = in_w;
        if (in_w[31]) begin
            n_sval1 = (in_e == 8'd0) ? in_w : QNAN_BITS;
        end else if (in_e == 8'd0) begin
            n_sval1 = 32'd0;
        end else if (in_e == EXP_MAX) begin
            n_sval1 = in_w;
        end else begin
            n_spec1 = 1'b0;
        end
        if (in_e >= EXP_BIAS) begin
            n_expr1 = EXP_BIAS + ((in_e - EXP_BIAS) >> 1);
        end else begin
            n_expr1 = EXP_BIAS - ((8'd128 - in_e) >> 1);
        end
    end

    assign ha = {1'b1, r_a1[22:11]};
    assign hb = {1'b1, r_m1[22:11]};

    assign mul = r_hh2 + 26'(r_lh2) + 26'(r_hl2) + 26'd2;

    always_comb begin
        logic xe129;
        logic xe127;
        if (mul[25]) begin
            mulm  = mul[24:2];
            xe129 = r_even2;
            xe127 = 1'b0;
        end else begin
            mulm  = mul[23:1];
            xe129 = 1'b0;
            xe127 = !r_even2;
        end
        if (xe129) begin
            ma = {1'b1, mulm, 1'b0};
            mb = {1'b0, 1'b1, r_b2};
        end else if (xe127) begin
            ma = {1'b0, 1'b1, mulm};
            mb = {1'b1, r_b2, 1'b0};
        end else begin
            ma = {1'b1, mulm, 1'b0};
            mb = {1'b1, r_b2, 1'b0};
        end
        sum  = 26'(ma) + 26'(mb);
        mant = mb[24] ? sum[24:2] : sum[23:1];
        n_root = r_spec2 ? r_sval2 : {1'b0, r_expr2, mant};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_operand.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
        if (rdy1 && i_operand.valid) begin
            r_a1    <= rom_data[key][45:23];
            r_b1    <= rom_data[key][22:0];
            r_m1    <= in_m;
            r_even1 <= ~in_e[0];
            r_spec1 <= n_spec1;
            r_sval1 <= n_sval1;
            r_expr1 <= n_expr1;
        end
        if (rdy2 && r_v1) begin
            r_hh2   <= 26'(ha) * 26'(hb);
            r_lh2   <= 13'((24'(r_a1[10:0]) * 24'(hb)) >> 11);
            r_hl2   <= 13'((24'(ha) * 24'(r_m1[10:0])) >> 11);
            r_b2    <= r_b1;
            r_even2 <= r_even1;
            r_spec2 <= r_spec1;
            r_sval2 <= r_sval1;
            r_expr2 <= r_expr1;
        end
        if (rdy3 && r_v2) begin
            r_root3 <= n_root;
        end
    end

    assign o_root.valid = r_v3;
    assign o_root.root  = r_root3;

`ifndef SYNTHESIS
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && !o_root.ready) |=> o_root.valid)
        else $error("result dropped while stalled");
    a_stall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && !o_root.ready) |=> $stable(o_root.root))
        else $error("result changed while stalled");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_operand.ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input blocked with room in the pipeline");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import fsti_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsti_operand_if opnd_if();
    fsti_root_if    root_if();

    fp32_sqrt_table_interp_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_operand (opnd_if),
        .o_root    (root_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [22:0] slope_mant  [RomDepth];
    logic [22:0] offset_mant [RomDepth];

    logic [31:0] pending_ops[$];
    logic [31:0] expected_roots[$];
    int          error_count = 0;
    bit          op_busy = 1'b0;
    int          op_gap = 0;
    int          ready_gap = 0;
    bit          no_idle = 1'b0;
    int          idle_cycles = 0;

    // Round a real to the nearest single-precision value, ties to even.
    function automatic real round_single(real d);
        logic [63:0] b;
        logic [34:0] keep;
        logic [28:0] low;
        b    = $realtobits(d);
        keep = b[63:29];
        low  = b[28:0];
        if (low > 29'h1000_0000 || (low == 29'h1000_0000 && keep[0]))
            keep = keep + 1'b1;
        return $bitstoreal({keep, 29'b0});
    endfunction

    function automatic logic [22:0] single_mant(real d);
        logic [63:0] b;
        b = $realtobits(d);
        return b[51:29];
    endfunction

    task automatic fill_tables();
        int  n;
        int  dn;
        real s0, s1, af, td, tf, sq, num, den, bf;
        for (int k = 0; k < RomDepth; k++) begin
            if ((k & RomHalf) != 0) begin
                n  = 1024 + 2 * (k & (RomHalf - 1));
                dn = 2;
            end else begin
                n  = 512 + k;
                dn = 1;
            end
            s0  = $sqrt(n / 512.0);
            s1  = $sqrt((n + dn) / 512.0);
            af  = round_single(1.0 / (s0 + s1));
            td  = (2.0 * af) * s0 - 1.0;
            tf  = round_single(td);
            sq  = round_single(tf * tf);
            num = round_single(2.0 - sq);
            den = round_single(8.0 * af);
            bf  = round_single(num / den);
            slope_mant[k]  = single_mant(af);
            offset_mant[k] = single_mant(bf);
        end
    endtask

    function automatic logic [31:0] predict_root(logic [31:0] x);
        logic [7:0]  e;
        logic [22:0] m;
        logic [9:0]  key;
        logic [31:0] expr, a, b, ha, hb, la, lb, prod, xe, ma, mb, total, mant;
        e   = x[30:23];
        m   = x[22:0];
        key = {~e[0], m[22:14]};
        if (x[31])
            return (e == 8'd0) ? x : QNAN_BITS;
        if (e == 8'd0)
            return 32'd0;
        if (e == EXP_MAX)
            return x;
        if (e >= EXP_BIAS)
            expr = 127 + ((32'(e) - 127) >> 1);
        else
            expr = 127 - ((128 - 32'(e)) >> 1);
        a    = 32'(slope_mant[key]);
        b    = 32'(offset_mant[key]);
        ha   = (a >> 11) | (32'd1 << 12);
        hb   = (32'(m) >> 11) | (32'd1 << 12);
        la   = a & 32'h7FF;
        lb   = 32'(m) & 32'h7FF;
        prod = ha * hb + ((la * hb) >> 11) + ((ha * lb) >> 11) + 32'd2;
        if (prod[25]) begin
            prod = (prod >> 2) & 32'h7F_FFFF;
            xe   = e[0] ? 128 : 129;
        end else begin
            prod = (prod >> 1) & 32'h7F_FFFF;
            xe   = e[0] ? 127 : 128;
        end
        if (xe == 129) begin
            ma = (prod | (32'd1 << 23)) << 1;
            mb = b | (32'd1 << 23);
        end else if (xe == 127) begin
            ma = prod | (32'd1 << 23);
            mb = (b | (32'd1 << 23)) << 1;
        end else begin
            ma = (prod | (32'd1 << 23)) << 1;
            mb = (b | (32'd1 << 23)) << 1;
        end
        total = ma + mb;
        mant  = (mb[24] ? (total >> 2) : (total >> 1)) & 32'h7F_FFFF;
        return {1'b0, expr[7:0], mant[22:0]};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %08h expected %08h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    // Sender: a new request goes out only after the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            opnd_if.valid   <= 1'b0;
            opnd_if.operand <= '0;
        end else if (!op_busy) begin
            if (op_gap > 0) begin
                op_gap--;
                opnd_if.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                opnd_if.operand <= pending_ops.pop_front();
                opnd_if.valid   <= 1'b1;
                op_busy = 1'b1;
                op_gap  = pick_gap();
            end else begin
                opnd_if.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            root_if.ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            root_if.ready <= 1'b0;
        end else begin
            root_if.ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (opnd_if.valid && opnd_if.ready) begin
                expected_roots.push_back(predict_root(opnd_if.operand));
                op_busy = 1'b0;
            end
            if (root_if.valid && root_if.ready) begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected root", root_if.root, 32'h0);
                else
                    begin
                        logic [31:0] want;
                        want = expected_roots.pop_front();
                        if (root_if.root !== want)
                            report_mismatch("root", root_if.root, want);
                    end
            end
            if ((opnd_if.valid && opnd_if.ready) || (root_if.valid && root_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 2000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] w;
        opnd_if.valid   = 1'b0;
        opnd_if.operand = '0;
        root_if.ready   = 1'b0;
        fill_tables();
        pending_ops = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0001, 32'h807F_FFFF,
                        32'hBF80_0000, 32'hFF80_0000, 32'hFFC0_0000, 32'hFFFF_FFFF,
                        32'h0000_0001, 32'h007F_FFFF, 32'h7F80_0000, 32'h7FC0_0001,
                        32'h7FFF_FFFF, 32'h3F80_0000, 32'h4000_0000, 32'h7F7F_FFFF,
                        32'h0080_0000, 32'h3FFF_FFFF, 32'h407F_FFFF, 32'h4080_0000,
                        32'h3F7F_FFFF, 32'h0100_0000, 32'h40FF_C000};
        for (int i = 0; i < 800; i++) begin
            if ($urandom_range(0, 9) < 8)
                w = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
            else
                w = $urandom;
            pending_ops.push_back(w);
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // Alternate between stretches with idling and stretches without.
        while (pending_ops.size() > 0 || op_busy) begin
            repeat (150) @(posedge i_clk);
            no_idle = !no_idle;
        end
        while (expected_roots.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fsti_pkg.sv
rtl/core/fsti_if.sv
rtl/core/fp32_sqrt_table_interp_core.sv
tb/testbench.sv
